[rtl/core/irrigation_pump_scheduler_assert.svh]
// Assertion macros used by the scheduler's checker file.
`ifndef IRRIGATION_PUMP_SCHEDULER_ASSERT_SVH
`define IRRIGATION_PUMP_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define IPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define IPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ips_pkg.sv]
`default_nettype none

package ips_pkg;

    // Field widths of the tick word and the result word.
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int WEEKDAY_W = 3;
    localparam int LEVEL_W   = 10;
    localparam int CODE_W    = 3;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int SECONDS_W = 8;
    localparam int DAYS_W    = 7;

    // Width of the shared subtractor: holds 10 * sample and 11 * largest reference.
    localparam int CMP_W     = 14;
    // Reference point index, up to eight points.
    localparam int IDX_W     = 3;
    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Defaults of the module parameters.
    localparam int LEVEL_POINTS_DEF = 5;
    localparam int SAMPLE_BITS_DEF  = 10;

    // Run modes.
    localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd2;

    // End status codes.
    localparam logic [STATUS_W-1:0] END_NONE  = 2'd0;
    localparam logic [STATUS_W-1:0] END_DONE  = 2'd1;
    localparam logic [STATUS_W-1:0] END_USER  = 2'd2;
    localparam logic [STATUS_W-1:0] END_FAULT = 2'd3;

    // Level codes with a special meaning.
    localparam logic [CODE_W-1:0] LEVEL_EMPTY = 3'd0;
    localparam logic [CODE_W-1:0] LEVEL_ERROR = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_HOUR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_DIVISOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_SECONDS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAY_MASK       = 3'd3;

    // Configuration reset values.
    localparam logic [HOUR_W-1:0]    START_HOUR_RST     = 5'd0;
    localparam logic [MINUTE_W-1:0]  MINUTE_DIVISOR_RST = 6'd60;
    localparam logic [SECONDS_W-1:0] RUN_SECONDS_RST    = 8'd10;
    localparam logic [DAYS_W-1:0]    DAY_MASK_RST       = 7'd0;

    // Configuration register set.
    typedef struct packed {
        logic [HOUR_W-1:0]    start_hour;
        logic [MINUTE_W-1:0]  minute_divisor;
        logic [SECONDS_W-1:0] run_seconds;
        logic [DAYS_W-1:0]    day_mask;
    } cfg_t;

    // One tick after classification and the minute check.
    typedef struct packed {
        logic [HOUR_W-1:0]    hour;
        logic [WEEKDAY_W-1:0] weekday;
        logic [CODE_W-1:0]    level_code;
        logic                 minute_match;
        logic                 auto_enable;
        logic                 manual_start;
        logic                 button_press;
    } tick_t;

    // Lower bound 9 * ref of each reference point; unused points never match.
    function automatic logic [CMP_W-1:0] lo_bound(input logic [IDX_W-1:0] idx);
        logic [CMP_W-1:0] v;
        case (idx)
            3'd0:    v = 14'd3987;
            3'd1:    v = 14'd4275;
            3'd2:    v = 14'd5157;
            3'd3:    v = 14'd6318;
            3'd4:    v = 14'd8190;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

    // Upper bound 11 * ref of each reference point.
    function automatic logic [CMP_W-1:0] hi_bound(input logic [IDX_W-1:0] idx);
        logic [CMP_W-1:0] v;
        case (idx)
            3'd0:    v = 14'd4873;
            3'd1:    v = 14'd5225;
            3'd2:    v = 14'd6303;
            3'd3:    v = 14'd7722;
            3'd4:    v = 14'd10010;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ips_alu.sv]
`default_nettype none

module ips_alu #(
    parameter int W = ips_pkg::CMP_W
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic      [W-1:0] diff,
    output logic              borrow
);

    // Shared subtractor: borrow set means a is below b.
    assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

`default_nettype wire

[rtl/core/ips_engine.sv]
`default_nettype none

module ips_engine #(
    parameter int LEVEL_POINTS = ips_pkg::LEVEL_POINTS_DEF,
    parameter int SAMPLE_BITS  = ips_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [ips_pkg::HOUR_W-1:0]     hour,
    input  wire logic [ips_pkg::MINUTE_W-1:0]   minute,
    input  wire logic [ips_pkg::WEEKDAY_W-1:0]  weekday,
    input  wire logic [ips_pkg::LEVEL_W-1:0]    level_sample,
    input  wire logic                           auto_enable,
    input  wire logic                           manual_start,
    input  wire logic                           button_press,
    input  wire logic [ips_pkg::MINUTE_W-1:0]   minute_divisor,
    input  wire logic                           out_free,
    output logic                                idle,
    output logic                                done,
    output ips_pkg::tick_t                      tick
);

    import ips_pkg::*;

    // Sample bits that survive the mask.
    localparam int S_W = (SAMPLE_BITS < LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                state_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [2:0]            bit_reg;
    logic [MINUTE_W-1:0]   rem_reg;
    logic [CMP_W-1:0]      ten_s_reg;
    logic [CODE_W-1:0]     level_reg;
    logic [HOUR_W-1:0]     hour_reg;
    logic [MINUTE_W-1:0]   minute_reg;
    logic [WEEKDAY_W-1:0]  weekday_reg;
    logic                  auto_reg;
    logic                  manual_reg;
    logic                  button_reg;

    logic [S_W-1:0]        sample;
    logic [CMP_W-1:0]      sample_ext;
    logic [CMP_W-1:0]      ten_s;
    logic [7:0]            minute_ext;
    logic [MINUTE_W:0]     shifted;
    logic [CMP_W-1:0]      alu_a;
    logic [CMP_W-1:0]      alu_b;
    logic [CMP_W-1:0]      alu_diff;
    logic                  alu_borrow;
    logic                  last_point;

    // Ten times the masked sample, as 8s + 2s.
    assign sample     = level_sample[S_W-1:0];
    assign sample_ext = CMP_W'(sample);
    assign ten_s      = (sample_ext << 3) + (sample_ext << 1);

    // Next partial remainder of the minute, one bit brought down per step.
    assign minute_ext = {2'b00, minute_reg};
    assign shifted    = {rem_reg, minute_ext[bit_reg]};
    assign last_point = (idx_reg == IDX_W'(LEVEL_POINTS - 1));

    // Operand selection for the shared subtractor.
    always_comb
    begin
        case (state_reg)
            ST_LO:
            begin
                alu_a = lo_bound(idx_reg);
                alu_b = ten_s_reg;
            end
            ST_HI:
            begin
                alu_a = ten_s_reg;
                alu_b = hi_bound(idx_reg);
            end
            ST_DIV:
            begin
                alu_a = CMP_W'(shifted);
                alu_b = CMP_W'(minute_divisor);
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    ips_alu #(
        .W(CMP_W)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .diff  (alu_diff),
        .borrow(alu_borrow)
    );

    // Sequencer: reference points one compare at a time, then six remainder steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            bit_reg     <= '0;
            rem_reg     <= '0;
            ten_s_reg   <= '0;
            level_reg   <= '0;
            hour_reg    <= '0;
            minute_reg  <= '0;
            weekday_reg <= '0;
            auto_reg    <= 1'b0;
            manual_reg  <= 1'b0;
            button_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        ten_s_reg   <= ten_s;
                        hour_reg    <= hour;
                        minute_reg  <= minute;
                        weekday_reg <= weekday;
                        auto_reg    <= auto_enable;
                        manual_reg  <= manual_start;
                        button_reg  <= button_press;
                        idx_reg     <= '0;
                        rem_reg     <= '0;
                        bit_reg     <= 3'(MINUTE_W - 1);
                        state_reg   <= ST_LO;
                    end
                end
                ST_LO:
                begin
                    // 9 * ref below 10 * s: go check the upper bound.
                    if (alu_borrow)
                    begin
                        state_reg <= ST_HI;
                    end
                    else if (last_point)
                    begin
                        level_reg <= LEVEL_ERROR;
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_HI:
                begin
                    if (alu_borrow)
                    begin
                        level_reg <= CODE_W'(idx_reg);
                        state_reg <= ST_DIV;
                    end
                    else if (last_point)
                    begin
                        level_reg <= LEVEL_ERROR;
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_LO;
                    end
                end
                ST_DIV:
                begin
                    // Restoring step: keep the difference when it does not borrow.
                    if (alu_borrow)
                    begin
                        rem_reg <= shifted[MINUTE_W-1:0];
                    end
                    else
                    begin
                        rem_reg <= alu_diff[MINUTE_W-1:0];
                    end
                    if (bit_reg == 3'd0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign idle = (state_reg == ST_IDLE);
    assign done = (state_reg == ST_DONE) && out_free;

    // Classified tick handed to the run controller.
    always_comb
    begin
        tick.hour         = hour_reg;
        tick.weekday      = weekday_reg;
        tick.level_code   = level_reg;
        tick.minute_match = (minute_reg != '0) && (minute_divisor != '0)
                            && (rem_reg == '0);
        tick.auto_enable  = auto_reg;
        tick.manual_start = manual_reg;
        tick.button_press = button_reg;
    end

endmodule

`default_nettype wire

[rtl/core/ips_run_ctrl.sv]
`default_nettype none

module ips_run_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            done,
    input  wire ips_pkg::tick_t  tick,
    input  wire ips_pkg::cfg_t   cfg,
    input  wire logic            m_axis_tready,
    output logic                 out_free,
    output logic                 m_axis_tvalid,
    output logic [7:0]           m_axis_tdata
);

    import ips_pkg::*;

    logic [MODE_W-1:0]    mode_reg;
    logic [SECONDS_W-1:0] elapsed_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_data_reg;

    logic [MODE_W-1:0]    mode_next;
    logic [SECONDS_W-1:0] elapsed_next;
    logic [STATUS_W-1:0]  status;
    logic [SECONDS_W-1:0] elapsed_inc;
    logic [7:0]           day_bits;
    logic                 fault;
    logic                 running;
    logic                 user_stop;
    logic                 auto_match;

    assign fault       = (tick.level_code == LEVEL_EMPTY) || (tick.level_code == LEVEL_ERROR);
    assign running     = (mode_reg == MODE_MANUAL) || (mode_reg == MODE_AUTO);
    assign user_stop   = (mode_reg == MODE_MANUAL) ? tick.button_press : !tick.auto_enable;
    assign elapsed_inc = elapsed_reg + 1'b1;
    // Weekday seven lands on the zero pad bit.
    assign day_bits    = {1'b0, cfg.day_mask};
    assign auto_match  = tick.auto_enable && !fault && (tick.hour == cfg.start_hour)
                         && tick.minute_match && day_bits[tick.weekday];

    // Run state decision for one tick.
    always_comb
    begin
        mode_next    = MODE_IDLE;
        elapsed_next = elapsed_reg;
        status       = END_NONE;
        if (running)
        begin
            mode_next = mode_reg;
            if (fault)
            begin
                status    = END_FAULT;
                mode_next = MODE_IDLE;
            end
            else if (user_stop)
            begin
                status    = END_USER;
                mode_next = MODE_IDLE;
            end
            else
            begin
                elapsed_next = elapsed_inc;
                if (elapsed_inc >= cfg.run_seconds)
                begin
                    status    = END_DONE;
                    mode_next = MODE_IDLE;
                end
            end
        end
        else if (auto_match)
        begin
            mode_next    = MODE_AUTO;
            elapsed_next = '0;
        end
        else if (tick.manual_start && !fault)
        begin
            mode_next    = MODE_MANUAL;
            elapsed_next = '0;
        end
    end

    // Run state and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (done)
            begin
                mode_reg      <= mode_next;
                elapsed_reg   <= elapsed_next;
                out_valid_reg <= 1'b1;
                out_data_reg  <= {status, mode_next, tick.level_code, mode_next != MODE_IDLE};
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

[rtl/core/irrigation_pump_scheduler.sv]
// Irrigation pump scheduler: each input word is one one-second tick carrying the clock time,
// the water level sample and the switch and button flags, and each tick yields exactly one
// result word with the pump state, level code, run mode and end status. For each tick one
// shared subtractor checks the lower and upper bound of each reference point in turn, so a
// match on the first point needs two compares and a sensor error up to two per point; then
// six restoring steps find the minute remainder, a done state hands the result over and the
// idle state takes the next word. s_axis_tready is low while a tick is in work; the result
// sits in an output register, so the next tick is accepted while it waits, but that tick
// holds in its last step until the earlier word has left.
`default_nettype none

module irrigation_pump_scheduler #(
    parameter int LEVEL_POINTS = ips_pkg::LEVEL_POINTS_DEF,
    parameter int SAMPLE_BITS  = ips_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // hour[4:0], minute[10:5], weekday[13:11], level_sample[23:14]
    input  wire logic [23:0]                       s_axis_tdata,
    // auto_enable[0], manual_start[1], button_press[2]
    input  wire logic [2:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // pump_on[0], level_code[3:1], run_mode[5:4], end_status[7:6]
    output logic [7:0]                             m_axis_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ips_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ips_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import ips_pkg::*;

    cfg_t  cfg_reg;
    tick_t tick;
    logic  idle;
    logic  done;
    logic  out_free;
    logic  start;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_hour     <= START_HOUR_RST;
            cfg_reg.minute_divisor <= MINUTE_DIVISOR_RST;
            cfg_reg.run_seconds    <= RUN_SECONDS_RST;
            cfg_reg.day_mask       <= DAY_MASK_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_START_HOUR:     cfg_reg.start_hour     <= cfg_data[HOUR_W-1:0];
                CFG_MINUTE_DIVISOR: cfg_reg.minute_divisor <= cfg_data[MINUTE_W-1:0];
                CFG_RUN_SECONDS:    cfg_reg.run_seconds    <= cfg_data[SECONDS_W-1:0];
                CFG_DAY_MASK:       cfg_reg.day_mask       <= cfg_data[DAYS_W-1:0];
                default:            ;
            endcase
        end
    end

    // A word is taken whenever the sequencer is idle.
    assign s_axis_tready = idle;
    assign start         = s_axis_tvalid && idle;

    ips_engine #(
        .LEVEL_POINTS(LEVEL_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .hour          (s_axis_tdata[4:0]),
        .minute        (s_axis_tdata[10:5]),
        .weekday       (s_axis_tdata[13:11]),
        .level_sample  (s_axis_tdata[23:14]),
        .auto_enable   (s_axis_tuser[0]),
        .manual_start  (s_axis_tuser[1]),
        .button_press  (s_axis_tuser[2]),
        .minute_divisor(cfg_reg.minute_divisor),
        .out_free      (out_free),
        .idle          (idle),
        .done          (done),
        .tick          (tick)
    );

    ips_run_ctrl u_run_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .done         (done),
        .tick         (tick),
        .cfg          (cfg_reg),
        .m_axis_tready(m_axis_tready),
        .out_free     (out_free),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tdata (m_axis_tdata)
    );

endmodule

`default_nettype wire

[rtl/core/ips_checker.sv]
`default_nettype none

`include "irrigation_pump_scheduler_assert.svh"

module ips_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [7:0]                        m_axis_tdata
);

    import ips_pkg::*;

    logic [8:0]          out_bus;
    logic                out_stall;
    logic                out_pump;
    logic                out_busy;
    logic [CODE_W-1:0]   out_code;
    logic [MODE_W-1:0]   out_mode;
    logic [STATUS_W-1:0] out_status;
    logic                out_ended;
    logic                out_fault_end;
    logic                out_fault_lvl;
    logic                in_take;

    // Fields of the result word and the handshake conditions.
    assign out_bus       = {m_axis_tvalid, m_axis_tdata};
    assign out_stall     = m_axis_tvalid && !m_axis_tready;
    assign out_pump      = m_axis_tdata[0];
    assign out_code      = m_axis_tdata[3:1];
    assign out_mode      = m_axis_tdata[5:4];
    assign out_status    = m_axis_tdata[7:6];
    assign out_busy      = (out_mode != MODE_IDLE);
    assign out_ended     = m_axis_tvalid && (out_status != END_NONE);
    assign out_fault_end = m_axis_tvalid && (out_status == END_FAULT);
    assign out_fault_lvl = (out_code == LEVEL_EMPTY) || (out_code == LEVEL_ERROR);
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // A stalled result word holds.
    `IPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, $stable(out_bus), "stalled word changed")

    // The pump runs exactly when a run is going.
    `IPS_ASSERT_NOW(a_pump_mode, clk, rst_n, m_axis_tvalid, out_pump == out_busy, "bad pump state")

    // A run that ends leaves the block idle.
    `IPS_ASSERT_NOW(a_end_idle, clk, rst_n, out_ended, out_mode == MODE_IDLE, "end while running")

    // A water fault stop comes only with an empty or error level.
    `IPS_ASSERT_NOW(a_fault_level, clk, rst_n, out_fault_end, out_fault_lvl, "no fault level")

    // One tick at a time: the input side is busy right after a word is taken.
    `IPS_ASSERT_NEXT(a_busy, clk, rst_n, in_take, !s_axis_tready, "ready after a word was taken")

endmodule

bind irrigation_pump_scheduler ips_checker u_ips_checker (.*);

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import ips_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 24;
    localparam int PHASES          = 8;
    localparam int TICKS_PER_PHASE = 90;

    // Software copy of the scheduler: registers, run state and the words still owed.
    class pump_schedule_model;

        typedef struct {
            logic                pump_on;
            logic [CODE_W-1:0]   level_code;
            logic [MODE_W-1:0]   run_mode;
            logic [STATUS_W-1:0] end_status;
        } result_word_t;

        logic [HOUR_W-1:0]    start_hour;
        logic [MINUTE_W-1:0]  minute_divisor;
        logic [SECONDS_W-1:0] run_seconds;
        logic [DAYS_W-1:0]    day_mask;
        logic [MODE_W-1:0]    run_state;
        logic [SECONDS_W-1:0] run_elapsed;
        int                   level_refs [5];
        result_word_t         expected_words [$];
        int                   mismatches;

        function new();
            start_hour     = START_HOUR_RST;
            minute_divisor = MINUTE_DIVISOR_RST;
            run_seconds    = RUN_SECONDS_RST;
            day_mask       = DAY_MASK_RST;
            run_state      = MODE_IDLE;
            run_elapsed    = '0;
            level_refs     = '{443, 475, 573, 702, 910};
            mismatches     = 0;
        endfunction

        // Register writes keep only the low bits of each register's width.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_START_HOUR:     start_hour     = data[HOUR_W-1:0];
                CFG_MINUTE_DIVISOR: minute_divisor = data[MINUTE_W-1:0];
                CFG_RUN_SECONDS:    run_seconds    = data[SECONDS_W-1:0];
                CFG_DAY_MASK:       day_mask       = data[DAYS_W-1:0];
                default:            ;
            endcase
        endfunction

        // First reference point whose open band holds the sample wins.
        function logic [CODE_W-1:0] level_code_of(logic [LEVEL_W-1:0] sample);
            int ten_s;
            ten_s = 10 * sample;
            for (int i = 0; i < 5; i++)
            begin
                if (ten_s > 9 * level_refs[i] && ten_s < 11 * level_refs[i])
                    return CODE_W'(i);
            end
            return LEVEL_ERROR;
        endfunction

        // Advance the run state by one tick word and queue the result it produces.
        function void take_tick(logic [23:0] d, logic [2:0] u);
            logic [HOUR_W-1:0]    hour;
            logic [MINUTE_W-1:0]  minute;
            logic [WEEKDAY_W-1:0] weekday;
            logic [CODE_W-1:0]    code;
            logic                 auto_on;
            logic                 manual;
            logic                 button;
            logic                 fault;
            logic                 stop_req;
            logic                 auto_match;
            result_word_t         r;
            hour    = d[4:0];
            minute  = d[10:5];
            weekday = d[13:11];
            code    = level_code_of(d[23:14]);
            auto_on = u[0];
            manual  = u[1];
            button  = u[2];
            fault   = (code == LEVEL_EMPTY) || (code == LEVEL_ERROR);
            r.end_status = END_NONE;
            if (run_state == MODE_MANUAL || run_state == MODE_AUTO)
            begin
                stop_req = (run_state == MODE_MANUAL) ? button : !auto_on;
                if (fault)
                begin
                    r.end_status = END_FAULT;
                    run_state    = MODE_IDLE;
                end
                else if (stop_req)
                begin
                    r.end_status = END_USER;
                    run_state    = MODE_IDLE;
                end
                else
                begin
                    run_elapsed = run_elapsed + 1'b1;
                    if (run_elapsed >= run_seconds)
                    begin
                        r.end_status = END_DONE;
                        run_state    = MODE_IDLE;
                    end
                end
            end
            else
            begin
                run_state  = MODE_IDLE;
                auto_match = auto_on && !fault && hour == start_hour && minute != 0 &&
                             minute_divisor != 0 && (minute % minute_divisor) == 0 &&
                             weekday < 7 && day_mask[weekday];
                if (auto_match)
                begin
                    run_state   = MODE_AUTO;
                    run_elapsed = '0;
                end
                else if (manual && !fault)
                begin
                    run_state   = MODE_MANUAL;
                    run_elapsed = '0;
                end
            end
            r.pump_on    = (run_state != MODE_IDLE);
            r.level_code = code;
            r.run_mode   = run_state;
            expected_words.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        // Compare one result word with the oldest expectation.
        task check_word(logic [7:0] w);
            result_word_t e;
            if (expected_words.size() == 0)
            begin
                report($sformatf("result word %h with nothing expected", w));
            end
            else
            begin
                e = expected_words.pop_front();
                if (w[0] !== e.pump_on)
                    report($sformatf("pump_on %b, expected %b", w[0], e.pump_on));
                if (w[3:1] !== e.level_code)
                    report($sformatf("level_code %0d, expected %0d", w[3:1], e.level_code));
                if (w[5:4] !== e.run_mode)
                    report($sformatf("run_mode %0d, expected %0d", w[5:4], e.run_mode));
                if (w[7:6] !== e.end_status)
                    report($sformatf("end_status %0d, expected %0d", w[7:6], e.end_status));
            end
        endtask

    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata = '0;
    logic [2:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pump_schedule_model schedule = new();
    bit                 steady_flow = 1'b0;
    int                 cycle_count = 0;

    irrigation_pump_scheduler uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Result side stalls at random except during the steady stretch.
    always @(posedge clk)
    begin
        m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 35);
    end

    // Every accepted result word goes to the checker.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            schedule.check_word(m_axis_tdata);
    end

    // Hard stop if the run hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one tick word, after an optional gap, and hold it until it is taken.
    task automatic send_tick(input logic [23:0] d, input logic [2:0] u);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(0, 99) < 35)
            gap = $urandom_range(1, 30);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= u;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        schedule.take_tick(d, u);
    endtask

    task automatic put_tick(input logic [HOUR_W-1:0] hour, input logic [MINUTE_W-1:0] minute,
                            input logic [WEEKDAY_W-1:0] weekday,
                            input logic [LEVEL_W-1:0] sample, input logic auto_on,
                            input logic manual, input logic button);
        send_tick({sample, weekday, minute, hour}, {button, manual, auto_on});
    endtask

    // Wait for every owed result, then let the block settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (schedule.expected_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register word; valid is left high so back-to-back writes need no dip.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        schedule.write_reg(idx, data);
    endtask

    // Load all registers, with junk in any unused upper bits, plus one write to a spare index.
    task automatic set_regs(input logic [HOUR_W-1:0] hour, input logic [MINUTE_W-1:0] div,
                            input logic [SECONDS_W-1:0] run_len, input logic [DAYS_W-1:0] mask);
        wait_idle();
        write_cfg(CFG_START_HOUR, {3'($urandom_range(0, 7)), hour});
        write_cfg(CFG_MINUTE_DIVISOR, {2'($urandom_range(0, 3)), div});
        write_cfg(CFG_RUN_SECONDS, run_len);
        write_cfg(CFG_DAY_MASK, {1'($urandom_range(0, 1)), mask});
        write_cfg(CFG_IDX_W'(CFG_DAY_MASK + $urandom_range(1, 4)), 8'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
    endtask

    // Mostly healthy water, often a scheduled time, with faults and random noise mixed in.
    task automatic random_tick();
        logic [HOUR_W-1:0]    hour;
        logic [MINUTE_W-1:0]  minute;
        logic [WEEKDAY_W-1:0] weekday;
        logic [LEVEL_W-1:0]   sample;
        int                   pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            sample = 10'($urandom_range(488, 522));
        else if (pick < 40)
            sample = 10'($urandom_range(523, 630));
        else if (pick < 60)
            sample = 10'($urandom_range(632, 772));
        else if (pick < 80)
            sample = 10'($urandom_range(820, 1000));
        else if (pick < 90)
            sample = 10'($urandom_range(399, 487));
        else
            sample = 10'($urandom_range(0, 1023));
        if ($urandom_range(0, 99) < 40)
        begin
            hour = schedule.start_hour;
            if (schedule.minute_divisor != 0)
                minute = 6'($urandom_range(1, 63 / schedule.minute_divisor) *
                            schedule.minute_divisor);
            else
                minute = 6'($urandom_range(0, 63));
            weekday = 3'($urandom_range(0, 7));
            if (schedule.day_mask != 0)
            begin
                while (!(weekday < 7 && schedule.day_mask[weekday]))
                    weekday = 3'($urandom_range(0, 6));
            end
        end
        else
        begin
            hour    = 5'($urandom_range(0, 31));
            minute  = 6'($urandom_range(0, 63));
            weekday = 3'($urandom_range(0, 7));
        end
        put_tick(hour, minute, weekday, sample, $urandom_range(0, 99) < 85,
                 $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 10);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: the day mask blocks automatic starts and a manual run lasts ten ticks.
        put_tick(0, 60, 0, 600, 1'b1, 1'b1, 1'b0);
        repeat (10) put_tick(0, 60, 0, 700, 1'b1, 1'b0, 1'b0);

        // Directed cases: Sunday, Tuesday and Friday allowed at 07:xx every 15 minutes.
        set_regs(7, 15, 3, 7'b0100101);
        put_tick(7, 15, 0, 0, 1'b1, 1'b1, 1'b0);     // sensor error refuses both starts
        put_tick(7, 15, 0, 1023, 1'b0, 1'b1, 1'b0);  // top of range is a sensor error
        put_tick(7, 20, 0, 450, 1'b0, 1'b1, 1'b0);   // empty tank refuses a manual start
        put_tick(7, 20, 0, 500, 1'b0, 1'b1, 1'b0);   // manual run begins
        put_tick(7, 20, 0, 600, 1'b0, 1'b1, 1'b0);   // second request during a run is ignored
        put_tick(7, 20, 0, 900, 1'b0, 1'b0, 1'b1);   // button stops a manual run
        put_tick(7, 20, 0, 700, 1'b0, 1'b1, 1'b0);
        put_tick(7, 20, 0, 398, 1'b0, 1'b0, 1'b1);   // fault wins over the button
        put_tick(7, 15, 0, 600, 1'b1, 1'b1, 1'b0);   // automatic match beats a manual request
        put_tick(7, 15, 0, 600, 1'b1, 1'b0, 1'b1);   // button is ignored in an automatic run
        put_tick(7, 15, 0, 600, 1'b0, 1'b0, 1'b0);   // switch off stops an automatic run
        put_tick(7, 45, 5, 820, 1'b1, 1'b0, 1'b0);
        put_tick(7, 45, 5, 999, 1'b1, 1'b0, 1'b0);
        put_tick(7, 45, 5, 632, 1'b1, 1'b0, 1'b0);
        put_tick(7, 45, 5, 523, 1'b1, 1'b0, 1'b0);   // run completes on the third tick after its start
        put_tick(7, 0, 0, 600, 1'b1, 1'b0, 1'b0);    // minute zero never matches
        put_tick(7, 30, 7, 600, 1'b1, 1'b0, 1'b0);   // weekday seven has no mask bit
        put_tick(7, 30, 1, 600, 1'b1, 1'b0, 1'b0);   // Monday is masked off
        put_tick(6, 15, 0, 600, 1'b1, 1'b0, 1'b0);   // wrong hour
        put_tick(31, 63, 7, 1000, 1'b1, 1'b0, 1'b1); // time field maxima, button while idle

        // Random phases, each under its own register setting.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       set_regs(5'($urandom_range(0, 23)), 1, 0, 7'h7F);
                1:       set_regs(23, 60, 1, 7'($urandom_range(0, 127)));
                2:       set_regs(0, 0, 8'($urandom_range(1, 15)), 7'h7F);
                3:       set_regs(31, 63, 255, 7'h7F);
                default: set_regs(5'($urandom_range(0, 23)), 6'($urandom_range(1, 60)),
                                  8'($urandom_range(1, 20)), 7'($urandom_range(0, 127)));
            endcase
            steady_flow = (p == 5);
            repeat (TICKS_PER_PHASE) random_tick();
        end
        steady_flow = 1'b0;
        wait_idle();

        if (schedule.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
